### hw/rtl/fdpf_pkg.sv
// Package: word types, register indices and limits for the flat derivative peak finder
`timescale 1ns / 1ps
package fdpf_pkg;

  localparam int AMP_W   = 16;
  localparam int POS_W   = 24;
  localparam int HWIN_W  = 23;
  localparam int IDX_W   = 16;
  localparam int CFG_W   = 23;
  localparam int CFGI_W  = 2;

  localparam longint MAX_SAMPLES   = 65536;
  localparam longint INDEX_LIMIT_L = (MAX_SAMPLES - 1 > 65535) ? 65535 : MAX_SAMPLES - 1;
  localparam logic [IDX_W-1:0] INDEX_LIMIT = IDX_W'(INDEX_LIMIT_L);
  localparam logic [IDX_W-1:0] COUNT_MAX   = '1;

  localparam logic [AMP_W-1:0]  THRESHOLD_RESET = 16'd20;
  localparam logic [HWIN_W-1:0] HALF_WINDOW_RESET = 23'd8388607;

  typedef enum logic [CFGI_W-1:0] {
    REG_FLAT_THRESHOLD = 2'd0,
    REG_HALF_WINDOW    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [AMP_W-1:0]        amplitude;
    logic                    end_of_curve;
  } sample_t;

  typedef struct packed {
    logic             peak_valid;
    logic [IDX_W-1:0] peak_index;
    logic [AMP_W-1:0] peak_value;
    logic [IDX_W-1:0] peak_count;
    logic             curve_done;
  } result_t;

  // Compare outcomes handed from the detector to the tracker
  typedef struct packed {
    logic flat;
    logic in_window;
    logic distinct;
  } flags_t;

endpackage

### hw/rtl/fdpf_detect.sv
// Slope, window and duplicate compares on the previous sample
`timescale 1ns / 1ps
module fdpf_detect (
  input  logic [fdpf_pkg::AMP_W-1:0]         cur_amplitude,
  input  logic [fdpf_pkg::AMP_W-1:0]         prev_amplitude,
  input  logic signed [fdpf_pkg::POS_W-1:0]  prev_position,
  input  logic [fdpf_pkg::AMP_W-1:0]         last_kept_value,
  input  logic [fdpf_pkg::AMP_W-1:0]         flat_threshold,
  input  logic [fdpf_pkg::HWIN_W-1:0]        half_window,
  output fdpf_pkg::flags_t                   flags
);
  import fdpf_pkg::*;

  logic [AMP_W-1:0] slope_mag;
  logic [AMP_W-1:0] dup_mag;
  logic [POS_W-1:0] pos_mag;

  always_comb begin
    slope_mag = (cur_amplitude > prev_amplitude) ? cur_amplitude - prev_amplitude
                                                 : prev_amplitude - cur_amplitude;
    dup_mag   = (prev_amplitude > last_kept_value) ? prev_amplitude - last_kept_value
                                                   : last_kept_value - prev_amplitude;
    // most negative position gives 0x800000, which lies outside any window
    pos_mag   = prev_position[POS_W-1] ? POS_W'(-prev_position) : prev_position;

    flags.flat      = slope_mag < flat_threshold;
    flags.in_window = pos_mag < {1'b0, half_window};
    flags.distinct  = dup_mag > flat_threshold;
  end

endmodule

### hw/rtl/fdpf_track.sv
// Curve state, peak decision and result register
`timescale 1ns / 1ps
module fdpf_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  fdpf_pkg::sample_t            item,
  input  logic [fdpf_pkg::AMP_W-1:0]   flat_threshold,
  input  logic [fdpf_pkg::HWIN_W-1:0]  half_window,
  output logic                         ready,
  output logic                         res_valid,
  input  logic                         res_stall,
  output fdpf_pkg::result_t            res
);
  import fdpf_pkg::*;

  logic [AMP_W-1:0]        prev_amplitude;
  logic signed [POS_W-1:0] prev_position;
  logic                    have_prev;
  logic [IDX_W-1:0]        sample_index;
  logic [AMP_W-1:0]        last_kept_value;
  logic                    any_kept;
  logic [IDX_W-1:0]        kept_count;

  flags_t           flags;
  logic             keep;
  logic [IDX_W-1:0] kept_count_next;
  logic [IDX_W-1:0] sample_index_next;
  result_t          res_next;

  fdpf_detect u_detect (
    .cur_amplitude  (item.amplitude),
    .prev_amplitude (prev_amplitude),
    .prev_position  (prev_position),
    .last_kept_value(last_kept_value),
    .flat_threshold (flat_threshold),
    .half_window    (half_window),
    .flags          (flags)
  );

  assign ready = !res_valid || !res_stall;

  always_comb begin
    keep = have_prev && flags.flat && flags.in_window && (!any_kept || flags.distinct);
    kept_count_next = (keep && kept_count != COUNT_MAX) ? kept_count + 16'd1 : kept_count;
    if (!have_prev) begin
      sample_index_next = '0;
    end else if (sample_index < INDEX_LIMIT) begin
      sample_index_next = sample_index + 16'd1;
    end else begin
      sample_index_next = INDEX_LIMIT;
    end
    res_next.peak_valid = keep;
    res_next.peak_index = keep ? sample_index : '0;
    res_next.peak_value = keep ? prev_amplitude : '0;
    res_next.peak_count = kept_count_next;
    res_next.curve_done = item.end_of_curve;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid       <= 1'b0;
      prev_amplitude  <= '0;
      prev_position   <= '0;
      have_prev       <= 1'b0;
      sample_index    <= '0;
      last_kept_value <= '0;
      any_kept        <= 1'b0;
      kept_count      <= '0;
    end else begin
      if (take) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        if (item.end_of_curve) begin
          prev_amplitude  <= '0;
          prev_position   <= '0;
          have_prev       <= 1'b0;
          sample_index    <= '0;
          last_kept_value <= '0;
          any_kept        <= 1'b0;
          kept_count      <= '0;
        end else begin
          prev_amplitude <= item.amplitude;
          prev_position  <= item.position;
          have_prev      <= 1'b1;
          sample_index   <= sample_index_next;
          kept_count     <= kept_count_next;
          if (keep) begin
            last_kept_value <= prev_amplitude;
            any_kept        <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_on_peak: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.peak_valid |-> res.peak_count != '0)
    else $error("peak reported with zero count");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.peak_valid |-> res.peak_index == '0 && res.peak_value == '0)
    else $error("index or value set without a peak");

  a_curve_clear: assert property (@(posedge clk) disable iff (rst)
    take && item.end_of_curve |=> !have_prev && kept_count == '0 && !any_kept)
    else $error("curve state not cleared after end of curve");

  a_index_start: assert property (@(posedge clk) disable iff (rst)
    !have_prev |-> sample_index == '0)
    else $error("sample index set with no previous sample");

  a_kept_pair: assert property (@(posedge clk) disable iff (rst)
    !any_kept |-> kept_count == '0)
    else $error("kept count nonzero with nothing kept");
`endif

endmodule

### hw/rtl/flat_derivative_peak_finder.sv
// Top level: input register, configuration registers and peak tracker
//
//  channel  direction  handshake              word
//  smp      in         smp_valid / smp_stall  fdpf_pkg::sample_t
//  res      out        res_valid / res_stall  fdpf_pkg::result_t
//  cfg      in         cfg_we                 cfg_index, cfg_data
//
// One word in, one word out. Each word passes the input register, then the
// compare and decision logic into the result register. A word is taken every
// cycle while the result side is not stalled. Synchronous reset clears the
// curve state and loads the register defaults. A stall on res holds the
// result register and backs up into the input register.
`timescale 1ns / 1ps
module flat_derivative_peak_finder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          smp_valid,
  output logic                          smp_stall,
  input  fdpf_pkg::sample_t             smp,
  output logic                          res_valid,
  input  logic                          res_stall,
  output fdpf_pkg::result_t             res,
  input  logic                          cfg_we,
  input  logic [fdpf_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [fdpf_pkg::CFG_W-1:0]    cfg_data
);
  import fdpf_pkg::*;

  logic               in_full;
  sample_t            in_word;
  logic               ready;
  logic               take;
  logic [AMP_W-1:0]   flat_threshold;
  logic [HWIN_W-1:0]  half_window;

  assign take      = in_full && ready;
  assign smp_stall = in_full && !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (smp_valid && !smp_stall) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid && !smp_stall) begin
      in_word <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_threshold <= THRESHOLD_RESET;
      half_window    <= HALF_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLAT_THRESHOLD: flat_threshold <= cfg_data[AMP_W-1:0];
        REG_HALF_WINDOW:    half_window    <= cfg_data[HWIN_W-1:0];
        default: ;
      endcase
    end
  end

  fdpf_track u_track (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item          (in_word),
    .flat_threshold(flat_threshold),
    .half_window   (half_window),
    .ready         (ready),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res)
  );

endmodule
